// ----- design/vdi_pkg.sv -----
package vdi_pkg;

    localparam int MaxUnique     = 256;
    localparam int MaxComponents = 8;
    localparam int Lanes         = 4;
    localparam int CompW         = 32;
    localparam int IdxW          = $clog2(MaxUnique);
    localparam int CntW          = IdxW + 1;
    localparam int RowW          = MaxComponents * CompW;
    localparam int LaneDepth     = MaxUnique / Lanes;
    localparam int LaneAddrW     = $clog2(LaneDepth);
    localparam int LaneSelW      = $clog2(Lanes);
    localparam int NcW           = 4;
    localparam int OutIdxW       = 8;

    typedef logic [CompW-1:0] t_comp;
    typedef logic [RowW-1:0]  t_row;

    function automatic logic is_nan(input t_comp b);
        is_nan = (b[30:0] > 31'h7F80_0000);
    endfunction

    function automatic logic comp_equal(input t_comp a, input t_comp b);
        logic r;
        r = 1'b0;
        if (is_nan(a) || is_nan(b)) begin
            r = 1'b0;
        end else if ((a[30:0] | b[30:0]) == 31'd0) begin
            r = 1'b1;
        end else begin
            r = (a == b);
        end
        comp_equal = r;
    endfunction

    // used components as a mask: 0 acts as 1, above MaxComponents clamps
    function automatic logic [MaxComponents-1:0] comp_mask(input logic [NcW-1:0] nc);
        logic [MaxComponents-1:0] m;
        m = '0;
        for (int c = 0; c < MaxComponents; c++) begin
            m[c] = (c == 0) || (NcW'(c) < nc);
        end
        comp_mask = m;
    endfunction

endpackage

// ----- design/vertex_dedup_indexer.sv -----
// Vertex deduplicating indexer. Each vertex transaction searches the
// stored unique vertices Lanes (4) entries per cycle, one per RAM lane,
// in insertion order; the first hit wins. Each item is held for its row scan
// through the lane RAMs; one item is in work at a time. The result
// sits in an output register, so the next vertex may be accepted while
// it waits. The RAM needs no clearing: the entry count bounds the scan.
module vertex_dedup_indexer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [3:0]  i_cfg_data,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_first_of_mesh,
    input  logic [31:0] i_component_0,
    input  logic [31:0] i_component_1,
    input  logic [31:0] i_component_2,
    input  logic [31:0] i_component_3,
    input  logic [31:0] i_component_4,
    input  logic [31:0] i_component_5,
    input  logic [31:0] i_component_6,
    input  logic [31:0] i_component_7,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_element_index,
    output logic        o_is_new,
    output logic        o_table_full
);
    localparam int L  = vdi_pkg::Lanes;
    localparam int AW = vdi_pkg::LaneAddrW;
    localparam int CW = vdi_pkg::CntW;

    localparam logic [1:0] StIdle  = 2'd0;
    localparam logic [1:0] StScan  = 2'd1;
    localparam logic [1:0] StDone  = 2'd2;

    logic [1:0]               r_state, n_state;
    logic [vdi_pkg::NcW-1:0]  r_nc;
    logic [CW-1:0]            r_count, n_count;
    vdi_pkg::t_row            r_vtx;
    logic [vdi_pkg::MaxComponents-1:0] r_mask;
    logic [CW-1:0]            r_rd_base;   // entry index of row being read
    logic                     r_cmp_vld;   // compare stage holds a row
    logic [CW-1:0]            r_cmp_base;
    logic                     r_hit;
    logic [vdi_pkg::IdxW-1:0] r_hit_idx;
    logic                     r_out_vld;
    logic [7:0]               r_out_idx;
    logic                     r_out_new, r_out_full;

    logic                     accept, out_free;
    logic [L-1:0]             lane_match, lane_live;
    logic                     row_hit;
    logic [vdi_pkg::IdxW-1:0] row_hit_idx;
    logic                     we;
    logic [L-1:0]             lane_we;
    logic [vdi_pkg::RowW-1:0] wmask;

    assign out_free    = !r_out_vld || !i_stall;
    assign o_stall     = (r_state != StIdle);
    assign accept      = i_valid && !o_stall;
    assign o_cfg_ready = (r_state == StIdle);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nc <= 4'd8;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_nc <= i_cfg_data;
        end
    end

    always_comb begin
        for (int c = 0; c < vdi_pkg::MaxComponents; c++) begin
            wmask[c*vdi_pkg::CompW +: vdi_pkg::CompW] = {vdi_pkg::CompW{r_mask[c]}};
        end
    end

    // lane merge: lowest lane with a live match is the earliest entry
    always_comb begin
        row_hit     = 1'b0;
        row_hit_idx = '0;
        for (int l = L - 1; l >= 0; l--) begin
            lane_live[l] = (r_cmp_base + CW'(l)) < r_count;
            if (lane_match[l] && lane_live[l]) begin
                row_hit     = 1'b1;
                row_hit_idx = vdi_pkg::IdxW'(r_cmp_base + CW'(l));
            end
        end
    end

    assign we = (r_state == StDone) && out_free && !r_hit
                && (r_count < CW'(vdi_pkg::MaxUnique));

    genvar g;
    generate
        for (g = 0; g < L; g++) begin : g_lane
            assign lane_we[g] = we &&
                (r_count[vdi_pkg::LaneSelW-1:0] == vdi_pkg::LaneSelW'(g));
            vdi_lane u_lane (
                .i_clk   (i_clk),
                .i_we    (lane_we[g]),
                .i_waddr (r_count[vdi_pkg::LaneSelW +: AW]),
                .i_wdata (r_vtx),
                .i_wmask (wmask),
                .i_raddr (r_rd_base[vdi_pkg::LaneSelW +: AW]),
                .i_vtx   (r_vtx),
                .i_mask  (r_mask),
                .o_match (lane_match[g])
            );
        end
    endgenerate

    always_comb begin
        n_state = r_state;
        n_count = r_count;
        case (r_state)
            StIdle: begin
                if (accept) begin
                    n_state = StScan;
                    if (i_first_of_mesh) n_count = '0;
                end
            end
            StScan: begin
                if ((r_cmp_vld && row_hit) ||
                    (!r_cmp_vld && r_rd_base >= r_count) ||
                    (r_cmp_vld && (r_cmp_base + CW'(L)) >= r_count)) begin
                    n_state = StDone;
                end
            end
            StDone: begin
                if (out_free) begin
                    n_state = StIdle;
                    if (we) n_count = r_count + 1'b1;
                end
            end
            default: n_state = StIdle;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= StIdle;
            r_count   <= '0;
            r_cmp_vld <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (r_state == StDone && out_free) begin
                r_out_vld <= 1'b1;
            end else if (!i_stall) begin
                r_out_vld <= 1'b0;
            end
            r_cmp_vld <= (r_state == StScan) && (n_state == StScan)
                         && (r_rd_base < r_count);
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_vtx <= {i_component_7, i_component_6, i_component_5, i_component_4,
                      i_component_3, i_component_2, i_component_1, i_component_0};
            r_mask    <= vdi_pkg::comp_mask(r_nc);
            r_rd_base <= '0;
            r_hit     <= 1'b0;
        end else if (r_state == StScan) begin
            r_rd_base  <= r_rd_base + CW'(L);
            r_cmp_base <= r_rd_base;
            if (r_cmp_vld && row_hit) begin
                r_hit     <= 1'b1;
                r_hit_idx <= row_hit_idx;
            end
        end
        if (r_state == StDone && out_free) begin
            if (r_hit) begin
                r_out_idx  <= 8'(r_hit_idx);
                r_out_new  <= 1'b0;
                r_out_full <= 1'b0;
            end else if (r_count < CW'(vdi_pkg::MaxUnique)) begin
                r_out_idx  <= 8'(r_count);
                r_out_new  <= 1'b1;
                r_out_full <= 1'b0;
            end else begin
                r_out_idx  <= '0;
                r_out_new  <= 1'b0;
                r_out_full <= 1'b1;
            end
        end
    end

    assign o_valid         = r_out_vld;
    assign o_element_index = r_out_idx;
    assign o_is_new        = r_out_new;
    assign o_table_full    = r_out_full;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(vdi_pkg::MaxUnique))
        else $error("entry count above table size");
    a_new_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (we && r_state == StDone) |=> (r_count == $past(r_count) + 1'b1))
        else $error("append did not grow count");
    a_one_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_is_new && o_table_full))
        else $error("new and full together");
endmodule

// ----- design/vdi_ram.sv -----
module vdi_ram #(
    parameter int Width = 32,
    parameter int Depth = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_waddr,
    input  logic [Width-1:0]         i_wdata,
    input  logic [Width-1:0]         i_wmask,
    input  logic [$clog2(Depth)-1:0] i_raddr,
    output logic [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];
    logic [Width-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= (r_mem[i_waddr] & ~i_wmask) | (i_wdata & i_wmask);
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ----- design/vdi_lane.sv -----
module vdi_lane (
    input  logic                        i_clk,
    input  logic                        i_we,
    input  logic [vdi_pkg::LaneAddrW-1:0] i_waddr,
    input  vdi_pkg::t_row               i_wdata,
    input  logic [vdi_pkg::RowW-1:0]    i_wmask,
    input  logic [vdi_pkg::LaneAddrW-1:0] i_raddr,
    input  vdi_pkg::t_row               i_vtx,
    input  logic [vdi_pkg::MaxComponents-1:0] i_mask,
    output logic                        o_match
);
    // One slice of the table: holds entries with index % Lanes == lane id,
    // compares the addressed row against the vertex in the cycle after the read.
    vdi_pkg::t_row rdata;
    logic [vdi_pkg::MaxComponents-1:0] eq;

    vdi_ram #(.Width(vdi_pkg::RowW), .Depth(vdi_pkg::LaneDepth)) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_we),
        .i_waddr (i_waddr),
        .i_wdata (i_wdata),
        .i_wmask (i_wmask),
        .i_raddr (i_raddr),
        .o_rdata (rdata)
    );

    always_comb begin
        for (int c = 0; c < vdi_pkg::MaxComponents; c++) begin
            eq[c] = !i_mask[c] || vdi_pkg::comp_equal(
                i_vtx[c*vdi_pkg::CompW +: vdi_pkg::CompW],
                rdata[c*vdi_pkg::CompW +: vdi_pkg::CompW]);
        end
    end

    assign o_match = &eq;
endmodule

// ----- tb/sv/tb_vertex_dedup_indexer.sv -----
`timescale 1ns / 1ps

module tb_vertex_dedup_indexer;

    typedef logic [vdi_pkg::MaxComponents-1:0][vdi_pkg::CompW-1:0] t_vtx;
    typedef struct packed {
        logic [vdi_pkg::OutIdxW-1:0] idx;
        logic                        is_new;
        logic                        full;
    } t_lookup;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [3:0]  i_cfg_data = '0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic        i_first_of_mesh = 1'b0;
    t_vtx        comp_bus = '0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [7:0]  o_element_index;
    logic        o_is_new;
    logic        o_table_full;

    vertex_dedup_indexer dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready), .i_cfg_data(i_cfg_data),
        .i_valid(i_valid), .o_stall(o_stall), .i_first_of_mesh(i_first_of_mesh),
        .i_component_0(comp_bus[0]), .i_component_1(comp_bus[1]),
        .i_component_2(comp_bus[2]), .i_component_3(comp_bus[3]),
        .i_component_4(comp_bus[4]), .i_component_5(comp_bus[5]),
        .i_component_6(comp_bus[6]), .i_component_7(comp_bus[7]),
        .o_valid(o_valid), .i_stall(i_stall),
        .o_element_index(o_element_index), .o_is_new(o_is_new),
        .o_table_full(o_table_full)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // predictor state
    logic [vdi_pkg::CompW-1:0] uniq_tbl [vdi_pkg::MaxUnique][vdi_pkg::MaxComponents];
    int unsigned      uniq_cnt;
    logic [3:0]       ncomp_reg;

    t_lookup lookups_due[$];
    int      send_idle_pct, recv_idle_pct;
    int      hold_req;
    int      errors, n_new, n_hit, n_full, n_items;

    function automatic logic word_nan(logic [vdi_pkg::CompW-1:0] b);
        return b[30:0] > 31'h7F80_0000;
    endfunction

    function automatic logic word_eq(logic [vdi_pkg::CompW-1:0] a,
                                     logic [vdi_pkg::CompW-1:0] b);
        if (word_nan(a) || word_nan(b)) return 1'b0;
        if (((a | b) & 32'h7FFF_FFFF) == 0) return 1'b1;
        return a == b;
    endfunction

    function automatic t_lookup dedup_lookup(logic fm, t_vtx v);
        int      n;
        logic    same;
        t_lookup r;
        n = (ncomp_reg == 0) ? 1 :
            (ncomp_reg > vdi_pkg::MaxComponents ? vdi_pkg::MaxComponents : ncomp_reg);
        if (fm) uniq_cnt = 0;
        for (int i = 0; i < uniq_cnt; i++) begin
            same = 1'b1;
            for (int c = 0; c < n; c++)
                if (!word_eq(v[c], uniq_tbl[i][c])) same = 1'b0;
            if (same) begin
                r.idx = i[7:0]; r.is_new = 1'b0; r.full = 1'b0;
                return r;
            end
        end
        if (uniq_cnt >= vdi_pkg::MaxUnique) begin
            r.idx = '0; r.is_new = 1'b0; r.full = 1'b1;
            return r;
        end
        for (int c = 0; c < n; c++) uniq_tbl[uniq_cnt][c] = v[c];
        r.idx = uniq_cnt[7:0]; r.is_new = 1'b1; r.full = 1'b0;
        uniq_cnt++;
        return r;
    endfunction

    // called and returning at a falling edge
    task automatic send_vertex(logic fm, t_vtx v);
        t_lookup r;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid         <= 1'b1;
        i_first_of_mesh <= fm;
        comp_bus        <= v;
        do @(posedge i_clk); while (o_stall);
        r = dedup_lookup(fm, v);
        lookups_due = {lookups_due, r};
        n_items++;
        @(negedge i_clk);
    endtask

    task automatic drain;
        i_valid <= 1'b0;
        while (lookups_due.size() != 0) @(negedge i_clk);
        repeat (80) @(negedge i_clk);
    endtask

    // every item yields a result, so an empty queue plus the pause means idle
    task automatic write_ncomp(logic [3:0] v);
        drain();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        ncomp_reg = v;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [vdi_pkg::CompW-1:0] rand_word();
        case ($urandom_range(0, 7))
            0: return 32'h0000_0000;
            1: return 32'h8000_0000;
            2: return {$urandom_range(0, 1) == 1, 8'hFF, 23'($urandom_range(1, 32'h7F_FFFF))};
            3: return $urandom_range(0, 1) ? 32'h7F80_0000 : 32'hFF80_0000;
            default: return $urandom;
        endcase
    endfunction

    function automatic t_vtx rand_vtx();
        t_vtx v;
        for (int c = 0; c < vdi_pkg::MaxComponents; c++) v[c] = rand_word();
        return v;
    endfunction

    always @(negedge i_clk) begin
        int hold_left;
        if (hold_req > 0) begin
            hold_left = hold_req;
            hold_req  = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_stall <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(0, 99) < recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        t_lookup e;
        if (i_rst_n && o_valid && !i_stall) begin
            if (lookups_due.size() == 0) begin
                $display("%0t: unexpected result idx=%0d new=%0b full=%0b", $time,
                         o_element_index, o_is_new, o_table_full);
                errors++;
            end else begin
                e = lookups_due.pop_front();
                if (e.idx != o_element_index || e.is_new != o_is_new
                        || e.full != o_table_full) begin
                    $display({"%0t: mismatch exp idx=%0d new=%0b full=%0b,",
                              " got idx=%0d new=%0b full=%0b"},
                             $time, e.idx, e.is_new, e.full,
                             o_element_index, o_is_new, o_table_full);
                    errors++;
                end
                if (e.full) n_full++; else if (e.is_new) n_new++; else n_hit++;
            end
        end
    end

    always @(posedge i_clk) begin
        int quiet;
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || (i_cfg_valid && o_cfg_ready))
            quiet = 0;
        else
            quiet++;
        if (quiet > 6000) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic test_specials;
        t_vtx z, m, nanv;
        z = '0;
        m = {vdi_pkg::MaxComponents{32'h8000_0000}};
        nanv = z; nanv[7] = 32'hFFFF_FFFF;
        send_vertex(1'b1, z);                       // new 0
        send_vertex(1'b0, m);                       // -0 matches +0
        send_vertex(1'b0, nanv);                    // NaN appended
        send_vertex(1'b0, nanv);                    // and again
        send_vertex(1'b0, {vdi_pkg::MaxComponents{32'h7F80_0000}});
        send_vertex(1'b0, {vdi_pkg::MaxComponents{32'h7F80_0000}});
        send_vertex(1'b0, {vdi_pkg::MaxComponents{32'h7FFF_FFFF}});
        send_vertex(1'b1, {vdi_pkg::MaxComponents{32'hFFFF_FFFF}});
        send_vertex(1'b0, {vdi_pkg::MaxComponents{32'hFF7F_FFFF}});
        send_vertex(1'b0, {vdi_pkg::MaxComponents{32'hFF7F_FFFF}});
    endtask

    task automatic test_comp_count;
        t_vtx a, b;
        a = '0; a[0] = 32'h3F80_0000;
        b = a;  b[1] = 32'h4000_0000;  b[7] = 32'h5555_AAAA;
        write_ncomp(4'd0);                          // acts as one component
        send_vertex(1'b1, a);
        send_vertex(1'b0, b);
        write_ncomp(4'd15);                         // clamps to eight
        send_vertex(1'b1, a);
        send_vertex(1'b0, b);
        send_vertex(1'b0, b);
        write_ncomp(4'd2);
        send_vertex(1'b1, a);
        send_vertex(1'b0, b);
        b[1] = 32'hC000_0000;
        send_vertex(1'b0, b);
    endtask

    task automatic test_table_full;
        t_vtx v;
        write_ncomp(4'd1);
        v = '0;
        for (int i = 0; i < vdi_pkg::MaxUnique + 2; i++) begin
            v[0] = 32'(i + 1);
            send_vertex(i == 0, v);
        end
        v[0] = 32'd5;
        send_vertex(1'b0, v);
        v[0] = 32'h7FC0_0000;
        send_vertex(1'b0, v);
    endtask

    task automatic test_backpressure;
        write_ncomp(4'd3);
        hold_req = 400;
        for (int i = 0; i < 30; i++) send_vertex(i == 0, rand_vtx());
    endtask

    task automatic test_random(int items, int sp, int rp);
        t_vtx pool [8];
        t_vtx v;
        int   left;
        send_idle_pct = sp;
        recv_idle_pct = rp;
        write_ncomp(4'($urandom_range(0, 15)));
        left = 0;
        for (int i = 0; i < items; i++) begin
            if (left == 0) begin
                left = $urandom_range(1, 60);
                foreach (pool[k]) pool[k] = rand_vtx();
            end
            if ($urandom_range(0, 99) < 60) begin
                v = pool[$urandom_range(0, 7)];
                // flip a zero sign now and then: still the same vertex
                for (int c = 0; c < vdi_pkg::MaxComponents; c++)
                    if ((v[c] & 32'h7FFF_FFFF) == 0 && $urandom_range(0, 1))
                        v[c][31] = ~v[c][31];
            end else begin
                v = rand_vtx();
            end
            send_vertex(left == 60 || i == 0 || $urandom_range(0, 99) == 0, v);
            left--;
            if (left == 59) left = 59;
        end
    endtask

    initial begin
        ncomp_reg = 4'd8;
        uniq_cnt  = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_req = 0;
        errors = 0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_specials();
        test_comp_count();
        test_table_full();
        test_backpressure();
        test_random(380, 38, 58);
        test_random(380, 58, 38);
        test_random(380, 0, 0);
        write_ncomp(4'd8);
        test_random(100, 20, 20);
        drain();

        $display("Covered %0d vertices: %0d appended, %0d matched, %0d on a full table,",
                 n_items, n_new, n_hit, n_full);
        $display("component counts 0..15, signed zeros, NaNs, mesh restarts and long stalls.");
        if (errors == 0 && lookups_due.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end
endmodule
